[hw/rtl/assert_macros.svh]
// Assertion macros for the port level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ECS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ECS_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/ecs_pkg.sv]
// -----------------------------------------------------------------------------
// ecs_pkg
// Shared constants, types and helper functions of the command suggestion block.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecs_pkg;

   localparam int MAX_COMMANDS = 16;
   localparam int MAX_LENGTH   = 32;
   localparam int ROW_LEN      = MAX_LENGTH + 1;

   localparam int SYM_W  = 8;
   localparam int DIST_W = 6;
   localparam int IDX_W  = 4;
   localparam logic [DIST_W-1:0] DIST_SAT = '1;

   localparam int CMD_W  = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
   localparam int CNT_W  = $clog2(MAX_COMMANDS + 1);
   localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
   localparam int J_W    = $clog2(MAX_LENGTH + 2);
   localparam int CHAR_DEPTH = MAX_COMMANDS * MAX_LENGTH;
   localparam int ROW_DEPTH  = MAX_COMMANDS * ROW_LEN;
   localparam int CHAR_AW = $clog2(CHAR_DEPTH);
   localparam int ROW_AW  = $clog2(ROW_DEPTH);

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_QUERY = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef struct packed {
      func_type           func;
      logic [SYM_W-1:0]   symbol;
      logic               last;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMD,
      ST_RUN,
      ST_DONE
   } state_type;

   function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
      return (v == DIST_SAT) ? DIST_SAT : v + 1'b1;
   endfunction

   function automatic logic [ROW_AW-1:0] row_addr(input logic [CMD_W-1:0] k,
                                                  input logic [J_W-1:0] j);
      return ROW_AW'(int'(k) * ROW_LEN + int'(j));
   endfunction

   function automatic logic [CHAR_AW-1:0] char_addr(input logic [CMD_W-1:0] k,
                                                    input logic [J_W-1:0] j);
      return CHAR_AW'(int'(k) * MAX_LENGTH + int'(j));
   endfunction

endpackage

[hw/rtl/ecs_front.sv]
// -----------------------------------------------------------------------------
// ecs_front
// Request intake: drops unused codes and queues the rest in a two-deep FIFO.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecs_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_func,
   input  logic [ecs_pkg::SYM_W-1:0] req_symbol,
   input  logic                     req_last,
   output logic                     q_valid,
   output ecs_pkg::item_type        q_item,
   input  logic                     q_pop
);
   import ecs_pkg::*;

   item_type   fifo_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req_stall = (cnt_ff == 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = fifo_ff[rd_ff];

   // Requests with the unused code are taken and thrown away.
   assign push = req_valid && !req_stall && (func_type'(req_func) != FUNC_NONE);

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ q_pop;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ff] <= '{func: func_type'(req_func), symbol: req_symbol, last: req_last};
      end
   end

endmodule

[hw/rtl/ecs_back.sv]
// -----------------------------------------------------------------------------
// ecs_back
// Execution engine: command table loads and the edit distance row sweep.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  ecs_pkg::item_type          q_item,
   output logic                       q_pop,
   input  logic [ecs_pkg::DIST_W-1:0] max_distance,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_found,
   output logic [ecs_pkg::IDX_W-1:0]  rsp_match_index,
   output logic [ecs_pkg::DIST_W-1:0] rsp_match_distance
);
   import ecs_pkg::*;

   logic [SYM_W-1:0]  char_mem [CHAR_DEPTH];
   logic [DIST_W-1:0] row_mem  [ROW_DEPTH];
   logic [LEN_W-1:0]  lengths_ff [MAX_COMMANDS];

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic              qs_ff, qs_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [J_W-1:0]    issue_ff, issue_in;
   logic              sv_ff, sv_in;
   logic [J_W-1:0]    sj_ff, sj_in;
   logic [DIST_W-1:0] left_ff, left_in;
   logic [DIST_W-1:0] diag_ff, diag_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic              last_ff, last_in;
   logic              fresh_ff, fresh_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              rv_ff, rv_in;
   logic              rf_ff, rf_in;
   logic [IDX_W-1:0]  ri_ff, ri_in;
   logic [DIST_W-1:0] rd_ff, rd_in;

   logic [SYM_W-1:0]  char_rd_ff;
   logic [DIST_W-1:0] row_rd_ff;

   logic              char_we;
   logic [CHAR_AW-1:0] char_wa;
   logic [DIST_W-1:0] up, dp_val, sub, best;
   logic [J_W-1:0]    issue_m1;

   assign rsp_valid          = rv_ff;
   assign rsp_found          = rf_ff;
   assign rsp_match_index    = ri_ff;
   assign rsp_match_distance = rd_ff;

   assign issue_m1 = issue_ff - 1'b1;

   // Cell of the distance row. On the first query byte the previous row is
   // the implicit 0, 1, 2, ... row, so the memory read is not used.
   always_comb begin
      if (!fresh_ff) begin
         up = row_rd_ff;
      end else if (int'(sj_ff) > int'(DIST_SAT)) begin
         up = DIST_SAT;
      end else begin
         up = DIST_W'(sj_ff);
      end
      sub  = (char_rd_ff == sym_ff) ? diag_ff : sat_inc(diag_ff);
      best = sat_inc(up);
      if (sat_inc(left_ff) < best) begin
         best = sat_inc(left_ff);
      end
      if (sub < best) begin
         best = sub;
      end
      dp_val = (sj_ff == '0) ? sat_inc(up) : best;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      qs_in    = qs_ff;
      k_in     = k_ff;
      len_in   = len_ff;
      issue_in = issue_ff;
      sv_in    = 1'b0;
      sj_in    = sj_ff;
      left_in  = left_ff;
      diag_in  = diag_ff;
      sym_in   = sym_ff;
      last_in  = last_ff;
      fresh_in = fresh_ff;
      found_in = found_ff;
      idx_in   = idx_ff;
      dist_in  = dist_ff;
      rv_in    = rv_ff && rsp_stall;
      rf_in    = rf_ff;
      ri_in    = ri_ff;
      rd_in    = rd_ff;
      q_pop    = 1'b0;
      char_we  = 1'b0;
      char_wa  = char_addr(count_ff[CMD_W-1:0], J_W'(pos_ff));

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_item.func)
                  FUNC_LOAD: begin
                     qs_in = 1'b0;
                     if (int'(count_ff) < MAX_COMMANDS) begin
                        if (int'(pos_ff) < MAX_LENGTH) begin
                           char_we = 1'b1;
                           pos_in  = pos_ff + 1'b1;
                        end
                        if (q_item.last) begin
                           count_in = count_ff + 1'b1;
                           pos_in   = '0;
                        end
                     end
                  end
                  FUNC_CLEAR: begin
                     count_in = '0;
                     pos_in   = '0;
                     qs_in    = 1'b0;
                  end
                  FUNC_QUERY: begin
                     sym_in   = q_item.symbol;
                     last_in  = q_item.last;
                     fresh_in = !qs_ff;
                     qs_in    = 1'b1;
                     k_in     = '0;
                     found_in = 1'b0;
                     idx_in   = '0;
                     dist_in  = '0;
                     state_in = ST_CMD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CMD: begin
            if (k_ff == count_ff) begin
               state_in = ST_DONE;
            end else begin
               len_in   = lengths_ff[k_ff[CMD_W-1:0]];
               issue_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (int'(issue_ff) <= int'(len_ff)) begin
               issue_in = issue_ff + 1'b1;
               sv_in    = 1'b1;
               sj_in    = issue_ff;
            end
            if (sv_ff) begin
               left_in = dp_val;
               diag_in = up;
               if (int'(sj_ff) == int'(len_ff)) begin
                  if (!found_ff && (dp_val <= max_distance)) begin
                     found_in = 1'b1;
                     idx_in   = IDX_W'(k_ff);
                     dist_in  = dp_val;
                  end
                  k_in     = k_ff + 1'b1;
                  sv_in    = 1'b0;
                  state_in = ST_CMD;
               end
            end
         end
         ST_DONE: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!rv_ff || !rsp_stall) begin
               qs_in    = 1'b0;
               rv_in    = 1'b1;
               rf_in    = found_ff;
               ri_in    = idx_ff;
               rd_in    = dist_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pos_ff   <= '0;
         qs_ff    <= 1'b0;
         sv_ff    <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         qs_ff    <= qs_in;
         sv_ff    <= sv_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      len_ff   <= len_in;
      issue_ff <= issue_in;
      sj_ff    <= sj_in;
      left_ff  <= left_in;
      diag_ff  <= diag_in;
      sym_ff   <= sym_in;
      last_ff  <= last_in;
      fresh_ff <= fresh_in;
      found_ff <= found_in;
      idx_ff   <= idx_in;
      dist_ff  <= dist_in;
      rf_ff    <= rf_in;
      ri_ff    <= ri_in;
      rd_ff    <= rd_in;
   end

   // Entry length is written when the closing byte of a command arrives.
   always_ff @(posedge clock) begin
      if (q_pop && (q_item.func == FUNC_LOAD) && q_item.last
          && (int'(count_ff) < MAX_COMMANDS)) begin
         lengths_ff[count_ff[CMD_W-1:0]] <= (int'(pos_ff) < MAX_LENGTH) ?
                                            pos_ff + 1'b1 : pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (char_we) begin
         char_mem[char_wa] <= q_item.symbol;
      end
      char_rd_ff <= char_mem[char_addr(k_ff[CMD_W-1:0], issue_m1)];
   end

   always_ff @(posedge clock) begin
      if (sv_ff) begin
         row_mem[row_addr(k_ff[CMD_W-1:0], sj_ff)] <= dp_val;
      end
      row_rd_ff <= row_mem[row_addr(k_ff[CMD_W-1:0], issue_ff)];
   end

endmodule

[hw/rtl/edit_distance_command_suggest.sv]
// -----------------------------------------------------------------------------
// edit_distance_command_suggest
// Suggests the closest registered command for a typed query by edit distance.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Commands are loaded one character per request (func load), a request with
// last set closes the entry; up to 16 commands of up to 32 characters are
// kept and extra characters or commands are dropped. Query characters
// (func query) each advance one Levenshtein row per stored command; the
// request with last set returns one response naming the first command, in
// load order, whose saturated distance is at most max_distance. The engine
// sweeps one dynamic programming cell per cycle through a single row memory
// port and a single character memory port. A two-deep request queue sits
// in front of the engine and a response register behind it, so new requests
// are taken while a response waits. max_distance is written over the csr
// port, which is always ready, and should only change while the block is
// idle.
module edit_distance_command_suggest (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_func,
   input  logic [7:0]                 req_symbol,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_found,
   output logic [3:0]                 rsp_match_index,
   output logic [5:0]                 rsp_match_distance,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [5:0]                 csr_max_distance
);
   import ecs_pkg::*;

   logic              q_valid;
   item_type          q_item;
   logic              q_pop;
   logic [DIST_W-1:0] max_distance_ff, max_distance_in;

   // The register port never holds off a write.
   assign csr_ready = 1'b1;

   always_comb begin
      max_distance_in = csr_valid ? csr_max_distance : max_distance_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_distance_ff <= DIST_W'(2);
      end else begin
         max_distance_ff <= max_distance_in;
      end
   end

   // Front end: takes requests and buffers them for the engine.
   ecs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_func   (req_func),
      .req_symbol (req_symbol),
      .req_last   (req_last),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // Back end: table storage, distance sweep and response register.
   ecs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .max_distance       (max_distance_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_match_index    (rsp_match_index),
      .rsp_match_distance (rsp_match_distance)
   );

endmodule

[hw/rtl/ecs_checker.sv]
// -----------------------------------------------------------------------------
// ecs_checker
// Port level checks of the command suggestion block, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ecs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_func,
   input logic [7:0] req_symbol,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_found,
   input logic [3:0] rsp_match_index,
   input logic [5:0] rsp_match_distance,
   input logic       csr_valid,
   input logic       csr_ready,
   input logic [5:0] csr_max_distance
);

   // A response without a match carries zero index and distance.
   `ECS_ASSERT(a_nomatch_zero, rsp_valid && !rsp_found |-> rsp_match_index == 4'd0 && rsp_match_distance == 6'd0, "no-match response carries nonzero fields")

   // After reset the queue is empty and no response is pending.
   `ECS_ASSERT_RST(a_reset_clean, $past(reset) |-> !rsp_valid && !req_stall, "state not clean after reset")

   // A stalled response stays valid.
   `ECS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "stalled response dropped")

   // A stalled response keeps its payload.
   `ECS_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_found) && $stable(rsp_match_index) && $stable(rsp_match_distance), "stalled response changed")

endmodule

bind edit_distance_command_suggest ecs_checker u_checker (.*);

[dv/ecs_checker.sv]
// -----------------------------------------------------------------------------
// ecs_scoreboard
// Watches the request, response and csr channels of the command suggestion
// block, predicts every response and compares it field by field.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecs_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_symbol,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_found,
   input  logic [3:0]  rsp_match_index,
   input  logic [5:0]  rsp_match_distance,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [5:0]  csr_max_distance,
   output int          fail_count,
   output int          pending,
   output int          checked
);
   import ecs_pkg::*;

   typedef struct packed {
      logic       found;
      logic [3:0] index;
      logic [5:0] distance;
   } suggestion_type;

   suggestion_type   suggestions_due[$];
   logic [7:0]       word_chars[MAX_COMMANDS][MAX_LENGTH];
   int               word_len[MAX_COMMANDS];
   logic [5:0]       dist_row[MAX_COMMANDS][ROW_LEN];
   int               word_count;
   int               fill_pos;
   logic             query_open;
   logic [5:0]       limit_dist;

   assign pending = suggestions_due.size();

   function automatic logic [5:0] bump(input logic [5:0] v);
      return (v == 6'd63) ? v : v + 6'd1;
   endfunction

   // One Levenshtein row step of every stored word against one query character.
   task automatic step_rows(input logic [7:0] sym);
      logic [5:0] diag, up, best, left, subst;
      for (int k = 0; k < word_count; k++) begin
         diag = dist_row[k][0];
         dist_row[k][0] = bump(dist_row[k][0]);
         for (int j = 1; j <= word_len[k]; j++) begin
            up = dist_row[k][j];
            best = bump(up);
            left = bump(dist_row[k][j-1]);
            subst = (word_chars[k][j-1] == sym) ? diag : bump(diag);
            if (left < best) best = left;
            if (subst < best) best = subst;
            diag = up;
            dist_row[k][j] = best;
         end
      end
   endtask

   task automatic take_request(input func_type f, input logic [7:0] sym, input logic lst);
      suggestion_type s;
      case (f)
         FUNC_LOAD: begin
            query_open = 1'b0;
            if (word_count < MAX_COMMANDS) begin
               if (fill_pos < MAX_LENGTH) begin
                  word_chars[word_count][fill_pos] = sym;
                  fill_pos++;
               end
               if (lst) begin
                  word_len[word_count] = fill_pos;
                  word_count++;
                  fill_pos = 0;
               end
            end
         end
         FUNC_CLEAR: begin
            word_count = 0;
            fill_pos = 0;
            query_open = 1'b0;
         end
         FUNC_QUERY: begin
            if (!query_open) begin
               for (int k = 0; k < word_count; k++)
                  for (int j = 0; j <= word_len[k]; j++)
                     dist_row[k][j] = 6'(j);
               query_open = 1'b1;
            end
            step_rows(sym);
            if (lst) begin
               query_open = 1'b0;
               s = '0;
               for (int k = 0; k < word_count; k++) begin
                  if (!s.found && dist_row[k][word_len[k]] <= limit_dist) begin
                     s.found = 1'b1;
                     s.index = 4'(k);
                     s.distance = dist_row[k][word_len[k]];
                  end
               end
               suggestions_due = {suggestions_due, s};
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      suggestion_type want;
      if (reset) begin
         word_count = 0;
         fill_pos = 0;
         query_open = 1'b0;
         limit_dist = 6'd2;
         fail_count <= 0;
         checked <= 0;
         suggestions_due.delete();
      end else begin
         if (csr_valid && csr_ready)
            limit_dist = csr_max_distance;
         if (rsp_valid && !rsp_stall) begin
            checked <= checked + 1;
            if (suggestions_due.size() == 0) begin
               if (fail_count < 10)
                  $display("ERROR: unexpected response found=%0d index=%0d distance=%0d",
                           rsp_found, rsp_match_index, rsp_match_distance);
               fail_count <= fail_count + 1;
            end else begin
               want = suggestions_due.pop_front();
               if (want.found !== rsp_found || want.index !== rsp_match_index ||
                   want.distance !== rsp_match_distance) begin
                  if (fail_count < 10)
                     $display("ERROR: response mismatch expected %0d/%0d/%0d got %0d/%0d/%0d",
                              want.found, want.index, want.distance,
                              rsp_found, rsp_match_index, rsp_match_distance);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            take_request(func_type'(req_func), req_symbol, req_last);
      end
   end

endmodule

[dv/testbench.sv]
// -----------------------------------------------------------------------------
// testbench
// Drives loads, queries, clears and csr writes into the command suggestion
// block under several idle and stall mixes; the checker predicts responses.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import ecs_pkg::*;

   // A query character keeps the engine busy for a whole sweep of the table and
   // three requests can be in flight, so quiet periods before csr writes and
   // at the end are sized to let all of them drain.
   localparam int SETTLE = 2000;
   localparam int CYCLE_LIMIT = 3000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [7:0]  req_symbol;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_found;
   logic [3:0]  rsp_match_index;
   logic [5:0]  rsp_match_distance;
   logic        csr_valid;
   logic        csr_ready;
   logic [5:0]  csr_max_distance;

   int          fail_count, pending, checked;
   int          cycles = 0;
   int          sent;
   int          gap_pct, stall_pct;

   // Stimulus-side copy of the words loaded so far, used only to build queries
   // that land near a stored word.
   logic [7:0]  known_chars[MAX_COMMANDS][40];
   int          known_len[MAX_COMMANDS];
   int          known_n;

   edit_distance_command_suggest dut (.*);

   ecs_scoreboard u_scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Cycle counter; a hung run ends here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // The response side stalls at the percentage of the current phase.
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // Sends one request. A gap may precede it; valid stays high from one
   // request to the next when no gap is drawn. Stall is sampled at the falling
   // edge, where it is stable, so the following rising edge is the acceptance.
   task automatic send(input func_type f, input logic [7:0] sym, input logic lst);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_symbol <= sym;
      req_last <= lst;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      @(posedge clock);
      sent++;
   endtask

   task automatic write_limit(input logic [5:0] value);
      wait (pending == 0);
      req_valid <= 1'b0;
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_max_distance <= value;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Letters from a small alphabet make near matches common; the full byte
   // range shows up now and then so every symbol bit toggles.
   function automatic logic [7:0] pick_symbol();
      return ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'(97 + $urandom_range(3));
   endfunction

   task automatic load_word(input int len);
      logic [7:0] c;
      for (int i = 0; i < len; i++) begin
         c = pick_symbol();
         if (known_n < MAX_COMMANDS && i < 40) known_chars[known_n][i] = c;
         send(FUNC_LOAD, c, i == len - 1);
      end
      if (known_n < MAX_COMMANDS) begin
         known_len[known_n] = (len > 40) ? 40 : len;
         known_n++;
      end
   endtask

   // A query is either a stored word with a few random edits or fresh text.
   // Now and then it is cut short by a load or a clear.
   task automatic query_word();
      logic [7:0] q[$];
      int k, edits, pos;
      if (known_n > 0 && $urandom_range(4) != 0) begin
         k = $urandom_range(known_n - 1);
         for (int i = 0; i < known_len[k]; i++) q = {q, known_chars[k][i]};
         edits = $urandom_range(3);
         for (int e = 0; e < edits; e++) begin
            pos = $urandom_range(q.size());
            case ($urandom_range(2))
               0: q.insert(pos, pick_symbol());
               1: if (pos < q.size()) q.delete(pos);
               default: if (pos < q.size()) q[pos] = pick_symbol();
            endcase
         end
      end
      if (q.size() == 0)
         repeat ($urandom_range(1, 8)) q = {q, pick_symbol()};
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, q.size())) send(FUNC_QUERY, pick_symbol(), 1'b0);
         if ($urandom_range(1) == 0) begin
            send(FUNC_CLEAR, pick_symbol(), 1'($urandom_range(1)));
            known_n = 0;
         end else begin
            load_word($urandom_range(1, 5));
         end
      end
      for (int i = 0; i < q.size(); i++)
         send(FUNC_QUERY, q[i], i == q.size() - 1);
   endtask

   task automatic random_batch(input int count);
      int goal, r;
      goal = sent + count;
      while (sent < goal) begin
         r = $urandom_range(99);
         if (r < 3) begin
            send(FUNC_CLEAR, pick_symbol(), 1'($urandom_range(1)));
            known_n = 0;
         end else if (r < 6) begin
            send(FUNC_NONE, pick_symbol(), 1'($urandom_range(1)));
         end else if (r < 40) begin
            // Mostly short words; a few overrun the length limit, and loads
            // past a full table exercise the drop path.
            load_word(($urandom_range(11) == 0) ? $urandom_range(30, 36)
                                                 : $urandom_range(1, 6));
         end else begin
            query_word();
         end
      end
   endtask

   task automatic send_text(input func_type f, input string s);
      for (int i = 0; i < s.len(); i++) send(f, s[i], i == s.len() - 1);
   endtask

   initial begin
      logic [5:0] limits[8];
      limits = '{6'd0, 6'd63, 6'd2, 6'd1, 6'd5, 6'd3, 6'd40, 6'd0};
      limits[5] = 6'($urandom_range(63));
      sent = 0;
      known_n = 0;
      gap_pct = 0;
      stall_pct = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_NONE;
      req_symbol <= '0;
      req_last <= 1'b0;
      csr_valid <= 1'b0;
      csr_max_distance <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: unused function code, a query on an empty table,
      // exact, near and missed queries, extreme symbol bytes, and queries
      // abandoned by a load and by a clear.
      write_limit(6'd2);
      send(FUNC_NONE, 8'hFF, 1'b1);
      send(FUNC_QUERY, "x", 1'b1);
      send_text(FUNC_LOAD, "go");
      send_text(FUNC_LOAD, "help");
      send(FUNC_LOAD, 8'h00, 1'b0);
      send(FUNC_LOAD, 8'hFF, 1'b1);
      send_text(FUNC_QUERY, "help");
      send_text(FUNC_QUERY, "hlp");
      send_text(FUNC_QUERY, "zzzzzz");
      send(FUNC_QUERY, 8'h00, 1'b0);
      send(FUNC_QUERY, 8'hFF, 1'b1);
      send(FUNC_QUERY, "h", 1'b0);
      send_text(FUNC_LOAD, "ls");
      send_text(FUNC_QUERY, "ls");
      send(FUNC_QUERY, "l", 1'b0);
      send(FUNC_CLEAR, 8'h00, 1'b0);
      send(FUNC_QUERY, "q", 1'b1);

      // Random part: eight phases, each under its own distance limit and
      // cycling through the idle and stall mixes.
      for (int p = 0; p < 8; p++) begin
         write_limit(limits[p]);
         gap_pct   = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 27 : 70) : 0;
         stall_pct = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 3) ? 27 : 70) : 0;
         random_batch(145);
      end
      req_valid <= 1'b0;

      wait (pending == 0);
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d requests and checked %0d suggestions over eight limit settings",
               sent, checked);
      $display("with loads past full tables, overlong words and abandoned queries.");
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ecs_pkg.sv
hw/rtl/ecs_front.sv
hw/rtl/ecs_back.sv
hw/rtl/edit_distance_command_suggest.sv
hw/rtl/ecs_checker.sv
dv/ecs_checker.sv
dv/testbench.sv
